>>> sv/bba_pkg.sv
// Package for the buddy block allocator: geometry constants, table entry
// layout, result status codes and sequencer states. No dependencies.
package bba_pkg;
  localparam int TotalLog2   = 24;
  localparam int MinLog2     = 10;
  localparam int HeaderBytes = 24;
  localparam int TopOrder    = TotalLog2 - MinLog2;
  localparam int Granules    = 1 << TopOrder;
  localparam int GW          = TopOrder;   // granule index width
  localparam int OW          = 5;          // stored order field width

  typedef logic [GW-1:0] gidx_t;
  typedef logic [OW-1:0] ord_t;

  typedef struct packed {
    logic start;
    logic used;
    ord_t ord;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_MERGE_RD, S_MERGE_CHK, S_DONE
  } state_t;
endpackage

>>> sv/bba_if.sv
// Valid/ready channel interfaces for the allocator. No dependencies.
interface bba_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        kind;
  logic [24:0] size_bytes;
  logic [23:0] block_address;
  modport source (output valid, kind, size_bytes, block_address, input ready);
  modport sink   (input valid, kind, size_bytes, block_address, output ready);
endinterface

interface bba_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [23:0] result_address;
  logic [1:0]  status;
  logic [3:0]  block_order;
  modport source (output valid, result_address, status, block_order, input ready);
  modport sink   (input valid, result_address, status, block_order, output ready);
endinterface

>>> sv/buddy_block_allocator_unit.sv
// Buddy allocator top level: sequencer over a granule table with one write port
// and one registered read port. Allocate: size the order (too large ends here),
// scan the table entries (up to 16384), then split a larger block if one is cut.
// Free: check the address, then merge with free buddies of equal order.
// One item at a time, one result each; ready again the cycle after the result
// transfer. After reset a clearing pass writes all 16384 entries.
module buddy_block_allocator_unit (
  input logic clk,
  input logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  entry_t  mem [Granules];
  entry_t  rd;
  gidx_t   addr, ptr, big, gcur;
  ord_t    k, ord, maxo, big_o;
  logic    big_ok, we;
  entry_t  wd;
  gidx_t   wa;
  state_t  state, state_next;
  logic [24:0] size_q;
  logic [23:0] baddr_q;
  logic [23:0] res_a;
  status_t res_s;
  logic [3:0] res_o;
  logic [25:0] need;
  logic [23:0] start_a;
  logic [GW:0] nxt;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[addr];
  end

  assign need    = {1'b0, size_q} + 26'(HeaderBytes);
  assign start_a = baddr_q - 24'(HeaderBytes);
  assign maxo    = (rd.ord > ord_t'(TopOrder)) ? ord_t'(TopOrder) : rd.ord;
  assign nxt     = {1'b0, ptr} + ((GW+1)'(1) << maxo);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (ptr == gidx_t'(Granules-1)) state_next = S_IDLE;
      S_IDLE:      if (req.valid) state_next = req.kind ? S_FREE_RD : S_SIZE;
      S_SIZE:      if (need > 26'(1 << TotalLog2)) state_next = S_DONE;
                   else if (k < ord_t'(TopOrder) &&
                            (26'(1) << (MinLog2 + int'(k))) < need) state_next = S_SIZE;
                   else state_next = S_SCAN_RD;
      S_SCAN_RD:   state_next = S_SCAN_CHK;
      S_SCAN_CHK:  if (!rd.start) state_next = nxt[GW] ? (big_ok ? S_SPLIT_RD : S_DONE)
                                                      : S_SCAN_RD;
                   else if (!rd.used && maxo == k) state_next = S_DONE;
                   else if (nxt[GW]) state_next = big_ok || (!rd.used && maxo > k)
                                                  ? S_SPLIT_RD : S_DONE;
                   else state_next = S_SCAN_RD;
      S_SPLIT_RD:  state_next = S_SPLIT;
      S_SPLIT:     if (ord <= k) state_next = S_DONE;
      S_FREE_RD:   state_next = S_FREE_CHK;
      S_FREE_CHK:  state_next = (rd.start && rd.used && res_s == ST_OK &&
                                 ord == '0) ? S_MERGE_RD : S_DONE;
      S_MERGE_RD:  state_next = S_MERGE_CHK;
      S_MERGE_CHK: state_next = (ord < ord_t'(TopOrder) && rd.start && !rd.used &&
                                 rd.ord == ord) ? S_MERGE_RD : S_DONE;
      S_DONE:      if (rsp.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we   = 1'b0;
    wa   = ptr;
    wd   = '0;
    addr = ptr;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wd = (ptr == '0) ? entry_t'{1'b1, 1'b0, ord_t'(TopOrder)} : '0;
      end
      // exact fit: mark the block used in place
      S_SCAN_CHK: if (rd.start && !rd.used && maxo == k) begin
        we = 1'b1;
        wa = ptr;
        wd = entry_t'{1'b1, 1'b1, k};
      end
      S_SPLIT_RD: addr = big;
      S_SPLIT: if (ord > k) begin
        we = 1'b1;
        wa = gcur + (gidx_t'(1) << (ord - 1'b1));
        wd = entry_t'{1'b1, 1'b0, ord - 1'b1};
      end else begin
        we = 1'b1;
        wa = gcur;
        wd = entry_t'{1'b1, 1'b1, k};
      end
      S_FREE_RD:  addr = start_a[MinLog2 +: GW];
      S_MERGE_RD: addr = gcur ^ (gidx_t'(1) << ord);
      S_MERGE_CHK: if (ord < ord_t'(TopOrder) && rd.start && !rd.used &&
                       rd.ord == ord) begin
        we = 1'b1;
        wa = gcur | (gidx_t'(1) << ord);
        wd = '0;
      end else begin
        we = 1'b1;
        wa = gcur;
        wd = entry_t'{1'b1, 1'b0, ord};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
    if (rst) ptr <= '0;
    else case (state)
      S_CLEAR:    ptr <= ptr + 1'b1;
      S_IDLE:     ptr <= '0;
      S_SCAN_CHK: ptr <= nxt[GW-1:0];
      default: ;
    endcase
    case (state)
      S_IDLE: if (req.valid) begin
        size_q <= req.size_bytes; baddr_q <= req.block_address;
        k <= '0; big_ok <= 1'b0; ord <= '0;
      end
      S_SIZE: if (need > 26'(1 << TotalLog2)) begin
        res_a <= '0; res_s <= ST_TOO_BIG; res_o <= '0;
      end else if (k < ord_t'(TopOrder) &&
                   (26'(1) << (MinLog2 + int'(k))) < need) k <= k + 1'b1;
      S_SCAN_CHK: if (rd.start && !rd.used) begin
        if (maxo == k) begin
          res_a <= {ptr, MinLog2'(0)} + 24'(HeaderBytes);
          res_s <= ST_OK; res_o <= k[3:0];
        end else if (maxo > k) begin
          big <= ptr; big_o <= maxo; big_ok <= 1'b1;
        end
        if (nxt[GW] && maxo != k && !(big_ok || maxo > k)) begin
          res_a <= '0; res_s <= ST_NO_BLOCK; res_o <= k[3:0];
        end
      end else if (nxt[GW] && !big_ok) begin
        res_a <= '0; res_s <= ST_NO_BLOCK; res_o <= k[3:0];
      end
      S_SPLIT_RD: begin
        gcur <= big; ord <= big_o;
      end
      S_SPLIT: if (ord > k) ord <= ord - 1'b1;
        else begin
          res_a <= {gcur, MinLog2'(0)} + 24'(HeaderBytes);
          res_s <= ST_OK; res_o <= k[3:0];
        end
      S_FREE_RD: begin
        gcur <= start_a[MinLog2 +: GW];
        res_a <= baddr_q; res_o <= '0;
        res_s <= (baddr_q < 24'(HeaderBytes) || start_a[MinLog2-1:0] != '0)
                 ? ST_BAD_FREE : ST_OK;
      end
      S_FREE_CHK: if (rd.start && rd.used && res_s == ST_OK) begin
        ord <= maxo; res_a <= start_a; res_o <= maxo[3:0];
      end else begin
        res_s <= ST_BAD_FREE; res_o <= '0; res_a <= baddr_q;
      end
      S_MERGE_CHK: if (ord < ord_t'(TopOrder) && rd.start && !rd.used &&
                       rd.ord == ord) begin
        gcur <= gcur & ~(gidx_t'(1) << ord); ord <= ord + 1'b1;
      end
      default: ;
    endcase
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = (state == S_DONE);
  assign rsp.result_address = res_a;
  assign rsp.status         = res_s;
  assign rsp.block_order    = res_o;

`ifndef NO_ASSERTIONS
  a_excl: assert property (@(posedge clk) disable iff (rst) !(req.ready && rsp.valid))
    else $error("ready and result valid together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_address))
    else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=> req.ready)
    else $error("no return to idle");
`endif
endmodule

>>> sim/testbench.sv
// Testbench for buddy_block_allocator_unit: directed table, then random
// alloc/free traffic checked against an in-bench buddy heap predictor.
// Depends on sv/bba_pkg.sv, sv/bba_if.sv and the top-level RTL.
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  localparam int LimitCycles = 25_000_000;
  localparam longint unsigned HeapBytes = 64'd1 << TotalLog2;

  typedef struct {
    logic [23:0] addr;
    status_t     st;
    logic [3:0]  ord;
  } result_t;

  typedef struct {
    bit          kind;
    int unsigned size;
    int unsigned addr;
    bit          fixed;
    result_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bba_req_if req_ch (clk);
  bba_rsp_if rsp_ch (clk);

  buddy_block_allocator_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  entry_t      heap_map [Granules];
  result_t     pending_results [$];
  int unsigned live_addrs [$];
  int unsigned freed_addrs [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.kind          = 1'b0;
    req_ch.size_bytes    = '0;
    req_ch.block_address = '0;
    rsp_ch.ready         = 1'b0;
  end

  task automatic heap_reset();
    foreach (heap_map[j]) heap_map[j] = '0;
    heap_map[0] = '{start: 1'b1, used: 1'b0, ord: ord_t'(TopOrder)};
  endtask

  task automatic alloc_model(input int unsigned size, output result_t r);
    longint unsigned need;
    int k, i, o, exact, bigger;
    entry_t e;
    need = longint'(size) + HeaderBytes;
    if (need > HeapBytes) begin
      r = '{addr: '0, st: ST_TOO_BIG, ord: '0};
      return;
    end
    k = 0;
    while (k < TopOrder && (64'd1 << (MinLog2 + k)) < need) k++;
    i = 0; exact = -1; bigger = -1;
    while (i < Granules) begin
      e = heap_map[i];
      if (!e.start) begin
        i++;
        continue;
      end
      o = (e.ord > TopOrder) ? TopOrder : int'(e.ord);
      if (!e.used) begin
        if (o == k) begin
          exact = i;
          break;
        end
        if (o > k) bigger = i;
      end
      i += 1 << o;
    end
    if (exact < 0) begin
      if (bigger < 0) begin
        r = '{addr: '0, st: ST_NO_BLOCK, ord: 4'(k)};
        return;
      end
      i = bigger;
      o = heap_map[i].ord;
      // halve, keeping the lower half; upper halves become free blocks
      while (o > k) begin
        o--;
        heap_map[(i + (1 << o)) % Granules] = '{start: 1'b1, used: 1'b0, ord: ord_t'(o)};
      end
    end else begin
      i = exact;
    end
    heap_map[i] = '{start: 1'b1, used: 1'b1, ord: ord_t'(k)};
    r = '{addr: 24'((i << MinLog2) + HeaderBytes), st: ST_OK, ord: 4'(k)};
  endtask

  task automatic free_model(input int unsigned addr, output result_t r);
    int unsigned blk_start;
    int g, b, o, freed_ord;
    entry_t e, be;
    r = '{addr: 24'(addr), st: ST_BAD_FREE, ord: '0};
    if (addr < HeaderBytes) return;
    blk_start = addr - HeaderBytes;
    if ((blk_start & ((1 << MinLog2) - 1)) != 0 || blk_start >= HeapBytes) return;
    g = blk_start >> MinLog2;
    e = heap_map[g];
    if (!e.start || !e.used) return;
    o = (e.ord > TopOrder) ? TopOrder : int'(e.ord);
    freed_ord = o;
    // merge upward while the buddy is a free block of equal order
    while (o < TopOrder) begin
      b = (g ^ (1 << o)) % Granules;
      be = heap_map[b];
      if (!be.start || be.used || be.ord != o) break;
      heap_map[(g > b) ? g : b] = '0;
      if (b < g) g = b;
      o++;
    end
    heap_map[g] = '{start: 1'b1, used: 1'b0, ord: ord_t'(o)};
    r = '{addr: 24'(blk_start), st: ST_OK, ord: 4'(freed_ord)};
  endtask

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input bit kind, input int unsigned size, input int unsigned addr,
                           input bit fixed, input result_t fixed_res);
    result_t r;
    int idx;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.size_bytes    <= 25'(size);
    req_ch.block_address <= 24'(addr);
    do @(posedge clk); while (!req_ch.ready);
    if (kind) begin
      free_model(addr & 24'hFFFFFF, r);
      if (r.st == ST_OK) begin
        foreach (live_addrs[j]) begin
          if (live_addrs[j] == addr) idx = j;
        end
        live_addrs.delete(idx);
        freed_addrs.push_back(addr);
      end
    end else begin
      alloc_model(size & 25'h1FFFFFF, r);
      if (r.st == ST_OK) live_addrs.push_back(r.addr);
    end
    pending_results.push_back(fixed ? fixed_res : r);
    @(negedge clk);
  endtask

  // response side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer addr=%h status=%0d order=%0d", $time,
                 rsp_ch.result_address, rsp_ch.status, rsp_ch.block_order);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.result_address !== want.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, want.addr,
                   rsp_ch.result_address);
          error_count++;
        end
        if (rsp_ch.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.block_order !== want.ord) begin
          $display("%0t: block_order expected %0d actual %0d", $time, want.ord,
                   rsp_ch.block_order);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic row_t mk(bit kind, int unsigned size, int unsigned addr, bit fixed,
                              logic [23:0] ea, status_t es, logic [3:0] eo);
    mk = '{kind: kind, size: size, addr: addr, fixed: fixed,
           res: '{addr: ea, st: es, ord: eo}};
  endfunction

  initial begin
    row_t        plan [$];
    row_t        row;
    result_t     none;
    int unsigned sz, pick;
    int          sel;
    none = '{addr: '0, st: ST_OK, ord: '0};
    heap_reset();
    // smallest alloc splits the whole heap down to granule 0
    plan.push_back(mk(0, 0, 24'h0, 1, 24, ST_OK, 0));
    plan.push_back(mk(0, 25'h1FFFFFF, 24'h0, 1, 0, ST_TOO_BIG, 0));
    plan.push_back(mk(0, 16777193, 24'hFFFFFF, 1, 0, ST_TOO_BIG, 0));
    plan.push_back(mk(0, 16777192, 24'h0, 1, 0, ST_NO_BLOCK, 14));
    plan.push_back(mk(1, 0, 0, 1, 0, ST_BAD_FREE, 0));
    plan.push_back(mk(1, 0, 23, 1, 23, ST_BAD_FREE, 0));
    plan.push_back(mk(1, 0, 25, 1, 25, ST_BAD_FREE, 0));
    plan.push_back(mk(1, 0, 1048, 1, 1048, ST_BAD_FREE, 0));   // free block
    plan.push_back(mk(1, 0, 3096, 1, 3096, ST_BAD_FREE, 0));   // no block start
    plan.push_back(mk(1, 0, 24'hFFFFFF, 1, 24'hFFFFFF, ST_BAD_FREE, 0));
    plan.push_back(mk(1, 25'h1FFFFFF, 24, 1, 0, ST_OK, 0));    // merges back to top
    plan.push_back(mk(1, 0, 24, 1, 24, ST_BAD_FREE, 0));       // double free
    plan.push_back(mk(0, 16777192, 0, 1, 24, ST_OK, 14));
    plan.push_back(mk(0, 0, 0, 1, 0, ST_NO_BLOCK, 0));
    plan.push_back(mk(1, 0, 24, 1, 0, ST_OK, 14));
    plan.push_back(mk(0, 1000, 0, 0, 0, ST_OK, 0));
    plan.push_back(mk(0, 1001, 0, 0, 0, ST_OK, 0));
    plan.push_back(mk(0, 0, 0, 0, 0, ST_OK, 0));
    plan.push_back(mk(0, 5000, 0, 0, 0, ST_OK, 0));
    plan.push_back(mk(0, 0, 0, 0, 0, ST_OK, 0));
    plan.push_back(mk(0, 1, 0, 0, 0, ST_OK, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[j]) begin
      row = plan[j];
      send_item(row.kind, row.size, row.addr, row.fixed, row.res);
    end

    for (int n = 0; n < 100; n++) begin
      if (n == 75) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (live_addrs.size() > 24) sel = 60;
      if (sel < 50 || (sel < 85 && live_addrs.size() == 0)) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) sz = $urandom_range(0, 8192);
        else if (pick < 95) sz = $urandom_range(0, 1 << 21);
        else sz = $urandom_range(0, 25'h1FFFFFF);
        send_item(0, sz, $urandom() & 24'hFFFFFF, 0, none);
      end else if (sel < 85) begin
        pick = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        send_item(1, $urandom() & 25'h1FFFFFF, pick, 0, none);
      end else if (sel < 92 && freed_addrs.size() > 0) begin
        pick = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
        send_item(1, 0, pick, 0, none);
      end else begin
        send_item(1, 0, $urandom() & 24'hFFFFFF, 0, none);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

>>> buddy_block_allocator_unit.f
sv/bba_pkg.sv
sv/bba_if.sv
sv/buddy_block_allocator_unit.sv
sim/testbench.sv
